### rtl/rtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and constants for the repeating timer table
// Kind and status codes, slot bookkeeping record and default sizes.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int DEF_TIMER_SLOTS = 16;
    localparam int DEF_TIME_WIDTH  = 32;

    // fire reports allowed per tick
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 16;
    localparam int IN_TIME_W = 32;

    localparam logic KIND_CREATE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic [1:0] STATUS_CREATED = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_TICK    = 2'd2;

    // per-slot bookkeeping that does not depend on the time width
    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  firings_left;
        logic [COUNT_W-1:0]  firings_done;
    } slot_meta_t;

    // what the slot unit did with the slot at the head of the chain
    typedef struct packed {
        logic fire;
        logic placed;
    } proc_stat_t;

endpackage

### rtl/rtt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_cell: one link of the slot chain
// Holds one timer slot and takes its neighbour's slot when the chain moves.
// ----------------------------------------------------------------------------
module rtt_cell #(
    parameter int TIME_WIDTH = rtt_pkg::DEF_TIME_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  rtt_pkg::slot_meta_t    meta_in,
    input  logic [TIME_WIDTH-1:0]  time_left_in,
    input  logic [TIME_WIDTH-1:0]  reload_in,
    output rtt_pkg::slot_meta_t    meta_out,
    output logic [TIME_WIDTH-1:0]  time_left_out,
    output logic [TIME_WIDTH-1:0]  reload_out
);

    logic                  valid_reg;
    logic [rtt_pkg::HANDLE_W-1:0] handle_reg;
    logic [rtt_pkg::COUNT_W-1:0]  left_reg;
    logic [rtt_pkg::COUNT_W-1:0]  done_reg;
    logic [TIME_WIDTH-1:0] time_left_reg;
    logic [TIME_WIDTH-1:0] reload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= meta_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            handle_reg    <= meta_in.handle;
            left_reg      <= meta_in.firings_left;
            done_reg      <= meta_in.firings_done;
            time_left_reg <= time_left_in;
            reload_reg    <= reload_in;
        end
    end

    always_comb
    begin
        meta_out.valid        = valid_reg;
        meta_out.handle       = handle_reg;
        meta_out.firings_left = left_reg;
        meta_out.firings_done = done_reg;
    end

    assign time_left_out = time_left_reg;
    assign reload_out    = reload_reg;

endmodule

### rtl/rtt_slot_proc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_slot_proc: update of the slot leaving the head of the chain
// Counts a live timer down on a tick and fires it, or fills a free slot
// on a create.
// ----------------------------------------------------------------------------
module rtt_slot_proc #(
    parameter int TIME_WIDTH = rtt_pkg::DEF_TIME_WIDTH
) (
    input  logic                          kind,
    input  logic [TIME_WIDTH-1:0]         duration,
    input  logic [rtt_pkg::COUNT_W-1:0]   repeat_count,
    input  logic [TIME_WIDTH-1:0]         elapsed,
    input  logic [rtt_pkg::HANDLE_W-1:0]  next_handle,
    input  logic                          found,
    input  logic                          fire_limit,
    input  rtt_pkg::slot_meta_t           meta_in,
    input  logic [TIME_WIDTH-1:0]         time_left_in,
    input  logic [TIME_WIDTH-1:0]         reload_in,
    output rtt_pkg::slot_meta_t           meta_out,
    output logic [TIME_WIDTH-1:0]         time_left_out,
    output logic [TIME_WIDTH-1:0]         reload_out,
    output rtt_pkg::proc_stat_t           stat
);

    logic [TIME_WIDTH-1:0]       dec;
    logic [rtt_pkg::COUNT_W-1:0] left_m1;

    always_comb
    begin
        dec     = (time_left_in > elapsed) ? (time_left_in - elapsed) : '0;
        left_m1 = meta_in.firings_left - rtt_pkg::COUNT_W'(1);

        meta_out      = meta_in;
        time_left_out = time_left_in;
        reload_out    = reload_in;
        stat.fire     = 1'b0;
        stat.placed   = 1'b0;

        if (kind == rtt_pkg::KIND_CREATE)
        begin
            if (!found && !meta_in.valid)
            begin
                stat.placed           = 1'b1;
                meta_out.valid        = 1'b1;
                meta_out.handle       = next_handle;
                meta_out.firings_left = (repeat_count == '0) ?
                                        rtt_pkg::COUNT_W'(1) : repeat_count;
                meta_out.firings_done = '0;
                time_left_out         = duration;
                reload_out            = duration;
            end
        end
        else if (meta_in.valid)
        begin
            time_left_out = dec;
            if (dec == '0 && !fire_limit)
            begin
                stat.fire             = 1'b1;
                meta_out.firings_done = meta_in.firings_done + rtt_pkg::COUNT_W'(1);
                meta_out.firings_left = left_m1;
                if (left_m1 == '0)
                begin
                    meta_out.valid = 1'b0;
                end
                else
                begin
                    time_left_out = reload_in;
                end
            end
        end
    end

endmodule

### rtl/repeating_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeating_timer_table: table of repeating countdown timers
// Slots sit in a ring of cells that turns once per command.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low. kind selects a
//   create (duration, repeat_count) or a tick (elapsed microseconds).
//   The slot ring turns one slot per cycle through a single update unit, and
//   busy stays high from the accepting edge until the ring has turned and
//   the final beat is registered; with start held high the next one is
//   taken at the end of the first cycle with busy low.
//   Results appear as beats on status/handle/call_index/fired/last, each
//   marked by result_strobe for one cycle; last flags the final beat of a
//   command. A create gives one beat at the end. A tick gives one beat per
//   firing timer in ascending slot order (at most 16), the earlier ones while
//   the ring turns and the final one after it, or a single quiet beat.
//   The final beat is strobed in the first cycle with busy low.
//   The receiver cannot stall: every beat must be taken when strobed.
//   Reset empties every slot and clears the handle counter; no clearing
//   pass is needed, the block is ready straight after reset.
// ----------------------------------------------------------------------------
module repeating_timer_table #(
    parameter int TIMER_SLOTS = rtt_pkg::DEF_TIMER_SLOTS,
    parameter int TIME_WIDTH  = rtt_pkg::DEF_TIME_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic [rtt_pkg::IN_TIME_W-1:0]       duration,
    input  logic [rtt_pkg::COUNT_W-1:0]         repeat_count,
    input  logic [rtt_pkg::IN_TIME_W-1:0]       elapsed,
    output logic                                result_strobe,
    output logic [1:0]                          status,
    output logic [rtt_pkg::HANDLE_W-1:0]        handle,
    output logic [rtt_pkg::COUNT_W-1:0]         call_index,
    output logic                                fired,
    output logic                                last
);

    localparam int STEP_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    logic                           kind_reg;
    logic [TIME_WIDTH-1:0]          dur_reg;
    logic [rtt_pkg::COUNT_W-1:0]    reps_reg;
    logic [TIME_WIDTH-1:0]          el_reg;
    logic                           found_reg, found_next;
    logic [rtt_pkg::FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic                           pend_reg, pend_next;
    logic [rtt_pkg::HANDLE_W-1:0]   pend_handle_reg, pend_handle_next;
    logic [rtt_pkg::COUNT_W-1:0]    pend_call_reg, pend_call_next;
    logic [rtt_pkg::HANDLE_W-1:0]   next_handle_reg, next_handle_next;

    logic                           strobe_reg, strobe_next;
    logic [1:0]                     status_reg, status_next;
    logic [rtt_pkg::HANDLE_W-1:0]   handle_reg, handle_next;
    logic [rtt_pkg::COUNT_W-1:0]    call_reg, call_next;
    logic                           fired_reg, fired_next;
    logic                           last_reg, last_next;

    logic                           accept;
    logic                           shift;
    logic                           fire_limit;

    rtt_pkg::slot_meta_t            meta_q [TIMER_SLOTS];
    logic [TIME_WIDTH-1:0]          tl_q   [TIMER_SLOTS];
    logic [TIME_WIDTH-1:0]          rl_q   [TIMER_SLOTS];

    rtt_pkg::slot_meta_t            proc_meta;
    logic [TIME_WIDTH-1:0]          proc_tl;
    logic [TIME_WIDTH-1:0]          proc_rl;
    rtt_pkg::proc_stat_t            proc_stat;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign shift      = (state_reg == ST_RUN);
    assign fire_limit = (fire_cnt_reg >= rtt_pkg::FIRE_CNT_W'(rtt_pkg::MAX_RESULTS));

    // ring of slot cells: head is cell 0, the updated slot re-enters at the tail
    genvar gi;
    generate
        for (gi = 0; gi < TIMER_SLOTS; gi++)
        begin : g_cell
            if (gi == TIMER_SLOTS - 1)
            begin : g_tail
                rtt_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
                    .clk           (clk),
                    .rst_n         (rst_n),
                    .shift         (shift),
                    .meta_in       (proc_meta),
                    .time_left_in  (proc_tl),
                    .reload_in     (proc_rl),
                    .meta_out      (meta_q[gi]),
                    .time_left_out (tl_q[gi]),
                    .reload_out    (rl_q[gi])
                );
            end
            else
            begin : g_body
                rtt_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
                    .clk           (clk),
                    .rst_n         (rst_n),
                    .shift         (shift),
                    .meta_in       (meta_q[gi+1]),
                    .time_left_in  (tl_q[gi+1]),
                    .reload_in     (rl_q[gi+1]),
                    .meta_out      (meta_q[gi]),
                    .time_left_out (tl_q[gi]),
                    .reload_out    (rl_q[gi])
                );
            end
        end
    endgenerate

    rtt_slot_proc #(.TIME_WIDTH(TIME_WIDTH)) u_proc (
        .kind          (kind_reg),
        .duration      (dur_reg),
        .repeat_count  (reps_reg),
        .elapsed       (el_reg),
        .next_handle   (next_handle_reg),
        .found         (found_reg),
        .fire_limit    (fire_limit),
        .meta_in       (meta_q[0]),
        .time_left_in  (tl_q[0]),
        .reload_in     (rl_q[0]),
        .meta_out      (proc_meta),
        .time_left_out (proc_tl),
        .reload_out    (proc_rl),
        .stat          (proc_stat)
    );

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        found_next       = found_reg;
        fire_cnt_next    = fire_cnt_reg;
        pend_next        = pend_reg;
        pend_handle_next = pend_handle_reg;
        pend_call_next   = pend_call_reg;
        next_handle_next = next_handle_reg;

        strobe_next = 1'b0;
        status_next = rtt_pkg::STATUS_TICK;
        handle_next = '0;
        call_next   = '0;
        fired_next  = 1'b0;
        last_next   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_RUN;
                    step_next     = '0;
                    found_next    = 1'b0;
                    fire_cnt_next = '0;
                    pend_next     = 1'b0;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + STEP_W'(1);
                if (proc_stat.placed)
                begin
                    found_next = 1'b1;
                end
                if (proc_stat.fire)
                begin
                    // hold the newest firing back until we know whether it is the final beat
                    if (pend_reg)
                    begin
                        strobe_next = 1'b1;
                        status_next = rtt_pkg::STATUS_TICK;
                        handle_next = pend_handle_reg;
                        call_next   = pend_call_reg;
                        fired_next  = 1'b1;
                    end
                    pend_next        = 1'b1;
                    pend_handle_next = meta_q[0].handle;
                    pend_call_next   = meta_q[0].firings_done;
                    fire_cnt_next    = fire_cnt_reg + rtt_pkg::FIRE_CNT_W'(1);
                end
                if (step_reg == STEP_W'(TIMER_SLOTS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next  = ST_IDLE;
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (kind_reg == rtt_pkg::KIND_CREATE)
                begin
                    if (found_reg)
                    begin
                        status_next      = rtt_pkg::STATUS_CREATED;
                        handle_next      = next_handle_reg;
                        next_handle_next = next_handle_reg + rtt_pkg::HANDLE_W'(1);
                    end
                    else
                    begin
                        status_next = rtt_pkg::STATUS_FULL;
                    end
                end
                else if (pend_reg)
                begin
                    handle_next = pend_handle_reg;
                    call_next   = pend_call_reg;
                    fired_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            found_reg       <= 1'b0;
            fire_cnt_reg    <= '0;
            pend_reg        <= 1'b0;
            next_handle_reg <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            found_reg       <= found_next;
            fire_cnt_reg    <= fire_cnt_next;
            pend_reg        <= pend_next;
            next_handle_reg <= next_handle_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            dur_reg  <= TIME_WIDTH'(duration);
            reps_reg <= repeat_count;
            el_reg   <= TIME_WIDTH'(elapsed);
        end
        pend_handle_reg <= pend_handle_next;
        pend_call_reg   <= pend_call_next;
        status_reg      <= status_next;
        handle_reg      <= handle_next;
        call_reg        <= call_next;
        fired_reg       <= fired_next;
        last_reg        <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign handle        = handle_reg;
    assign call_index    = call_reg;
    assign fired         = fired_reg;
    assign last          = last_reg;

endmodule
